### hw/rtl/slu_pkg.sv
package slu_pkg;

  // saturated step length: any larger step already covers every distance
  localparam int unsigned STEP_W = 36;
  localparam logic [STEP_W-1:0] STEP_CAP = 36'h8_0000_0000;

  localparam int unsigned LIN_SPEED_W = 23;
  localparam int unsigned ANG_SPEED_W = 23;
  localparam int unsigned PERIOD_W    = 20;
  localparam int unsigned RAMP_W      = 24;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANG  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP     = 2'd3;

  localparam logic [LIN_SPEED_W-1:0] MAX_LIN_RST = 23'd327680;
  localparam logic [ANG_SPEED_W-1:0] MAX_ANG_RST = 23'd411775;
  localparam logic [PERIOD_W-1:0]    PERIOD_RST  = 20'd20000;
  localparam logic [RAMP_W-1:0]      RAMP_RST    = 24'd500000;

  localparam logic CMD_LIMIT = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic start;
    logic sqrt;
  } iter_ctrl_t;

endpackage

### hw/rtl/slu_in_if.sv
interface slu_in_if #(
  parameter int SPEED_WIDTH = 24
);
  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic [SPEED_WIDTH-1:0] target_vx;
  logic [SPEED_WIDTH-1:0] target_vy;
  logic [SPEED_WIDTH-1:0] target_omega;

  modport source (output valid, cmd, target_vx, target_vy, target_omega, input ready);
  modport sink   (input valid, cmd, target_vx, target_vy, target_omega, output ready);
endinterface

### hw/rtl/slu_out_if.sv
interface slu_out_if #(
  parameter int SPEED_WIDTH = 24
);
  logic                   valid;
  logic                   ready;
  logic [SPEED_WIDTH-1:0] out_vx;
  logic [SPEED_WIDTH-1:0] out_vy;
  logic [SPEED_WIDTH-1:0] out_omega;

  modport source (output valid, out_vx, out_vy, out_omega, input ready);
  modport sink   (input valid, out_vx, out_vy, out_omega, output ready);
endinterface

### hw/rtl/slu_iter.sv
// Shared bit-serial unit: restoring divide (one bit a cycle) or
// digit-by-digit square root (two numerator bits a cycle).
module slu_iter #(
  parameter int MW = 25
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  slu_pkg::iter_ctrl_t   ctrl_i,
  input  logic [2*MW-1:0]       num_i,
  input  logic [MW:0]           den_i,
  output logic                  done_o,
  output logic [2*MW-1:0]       res_o
);
  localparam int NUM_W = 2 * MW;
  localparam int RW    = MW + 2;
  localparam int TW    = RW + 2;
  localparam int CW    = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [RW-1:0]    rem_q;
  logic [NUM_W-1:0] res_q;
  logic [MW:0]      den_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, sqrt_q, done_q;

  logic [TW-1:0] rem_sh, trial, rem_sub;
  logic          ge;

  always_comb begin
    if (sqrt_q) begin
      rem_sh = {rem_q, num_q[NUM_W-1:NUM_W-2]};
      trial  = {res_q[TW-3:0], 2'b01};
    end else begin
      rem_sh = {1'b0, rem_q, num_q[NUM_W-1]};
      trial  = TW'(den_q);
    end
    ge      = (rem_sh >= trial);
    rem_sub = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= ctrl_i.sqrt ? CW'(MW) : CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      num_q  <= num_i;
      den_q  <= den_i;
      sqrt_q <= ctrl_i.sqrt;
      rem_q  <= '0;
      res_q  <= '0;
    end else if (busy_q) begin
      num_q <= sqrt_q ? {num_q[NUM_W-3:0], 2'b00} : {num_q[NUM_W-2:0], 1'b0};
      rem_q <= rem_sub[RW-1:0];
      res_q <= {res_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;
endmodule

### hw/rtl/planar_velocity_slew_limiter_unit.sv
// Channel   Dir  Fields                                   Request taken when
// req_i     in   cmd, target_vx, target_vy, target_omega  req_i.valid & req_i.ready
// rsp_o     out  out_vx, out_vy, out_omega                rsp_o.valid & rsp_o.ready
// cfg_*     in   cfg_idx_i, cfg_wdata_i                   cfg_we_i
//
// One request at a time. A clear request has its result valid the cycle after acceptance.
// A limit request runs two step divides, one square root and, when the pair
// has to slew, two scaled divides, all on the shared unit slu_iter; the
// scaled divides are skipped when the pair jumps or its step is zero.
// Reset clears the limited speeds and loads the default registers.
// The result waits in the output registers until taken; req_i.ready stays
// low until then.
module planar_velocity_slew_limiter_unit #(
  parameter int SPEED_WIDTH = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  slu_in_if.sink                             req_i,
  slu_out_if.source                          rsp_o,
  input  logic                               cfg_we_i,
  input  logic [slu_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [slu_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  localparam int W     = SPEED_WIDTH;
  localparam int MW    = (W + 1 > 23) ? W + 1 : 23;   // shared multiplier operand width
  localparam int NUM_W = 2 * MW;
  localparam int SW    = slu_pkg::STEP_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_SQY    = 3'd2;
  localparam logic [2:0] ST_GO     = 3'd3;
  localparam logic [2:0] ST_WAIT   = 3'd4;
  localparam logic [2:0] ST_DECIDE = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  // jobs for the shared unit
  localparam logic [2:0] JOB_LIN  = 3'd0;
  localparam logic [2:0] JOB_ANG  = 3'd1;
  localparam logic [2:0] JOB_ROOT = 3'd2;
  localparam logic [2:0] JOB_QX   = 3'd3;
  localparam logic [2:0] JOB_QY   = 3'd4;

  // configuration
  logic [slu_pkg::LIN_SPEED_W-1:0] max_lin_q;
  logic [slu_pkg::ANG_SPEED_W-1:0] max_ang_q;
  logic [slu_pkg::PERIOD_W-1:0]    period_q;
  logic [slu_pkg::RAMP_W-1:0]      ramp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_lin_q <= slu_pkg::MAX_LIN_RST;
      max_ang_q <= slu_pkg::MAX_ANG_RST;
      period_q  <= slu_pkg::PERIOD_RST;
      ramp_q    <= slu_pkg::RAMP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        slu_pkg::CFG_MAX_LIN: max_lin_q <= cfg_wdata_i[slu_pkg::LIN_SPEED_W-1:0];
        slu_pkg::CFG_MAX_ANG: max_ang_q <= cfg_wdata_i[slu_pkg::ANG_SPEED_W-1:0];
        slu_pkg::CFG_PERIOD:  period_q  <= cfg_wdata_i[slu_pkg::PERIOD_W-1:0];
        slu_pkg::CFG_RAMP:    ramp_q    <= cfg_wdata_i[slu_pkg::RAMP_W-1:0];
        default: ;
      endcase
    end
  end

  // zero ramp time counts as one microsecond
  logic [slu_pkg::RAMP_W-1:0] ramp_nz;
  assign ramp_nz = (ramp_q == '0) ? slu_pkg::RAMP_W'(1) : ramp_q;

  logic [2:0] state_q, job_q;
  logic [W-1:0] vx_q, vy_q, w_q;          // limited speeds, also the result
  logic [W-1:0] tx_q, ty_q, tw_q;
  logic [W:0]   ax_q, ay_q, aw_q;         // magnitudes of the differences
  logic         sx_q, sy_q, sw_q;         // difference negative
  logic [SW-1:0] lin_q, ang_q;
  logic [W:0]   r_q, qx_q;
  logic [NUM_W-1:0] prod_q;

  // differences against the current state, taken at acceptance
  logic [W:0] dx, dy, dw;
  assign dx = {req_i.target_vx[W-1], req_i.target_vx} - {vx_q[W-1], vx_q};
  assign dy = {req_i.target_vy[W-1], req_i.target_vy} - {vy_q[W-1], vy_q};
  assign dw = {req_i.target_omega[W-1], req_i.target_omega} - {w_q[W-1], w_q};

  // shared multiplier
  logic [MW-1:0]    mul_a, mul_b;
  logic [NUM_W-1:0] mul_p;
  always_comb begin
    mul_a = MW'(ax_q);
    mul_b = MW'(ax_q);
    if (state_q == ST_SQY) begin
      mul_a = MW'(ay_q);
      mul_b = MW'(ay_q);
    end else begin
      unique case (job_q)
        JOB_LIN: begin
          mul_a = MW'(max_lin_q);
          mul_b = MW'(period_q);
        end
        JOB_ANG: begin
          mul_a = MW'(max_ang_q);
          mul_b = MW'(period_q);
        end
        JOB_ROOT: ;
        JOB_QX: mul_b = MW'(lin_q[W:0]);
        JOB_QY: begin
          mul_a = MW'(ay_q);
          mul_b = MW'(lin_q[W:0]);
        end
        default: ;
      endcase
    end
  end
  assign mul_p = mul_a * mul_b;

  // shared iterative unit
  slu_pkg::iter_ctrl_t iter_ctrl;
  logic [MW:0]         iter_den;
  logic                iter_done;
  logic [NUM_W-1:0]    iter_res;

  assign iter_ctrl.start = (state_q == ST_GO);
  assign iter_ctrl.sqrt  = (job_q == JOB_ROOT);
  assign iter_den = (job_q == JOB_LIN || job_q == JOB_ANG) ? (MW + 1)'(ramp_nz)
                                                           : (MW + 1)'(r_q);

  slu_iter #(.MW(MW)) u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (iter_ctrl),
    .num_i  (prod_q),
    .den_i  (iter_den),
    .done_o (iter_done),
    .res_o  (iter_res)
  );

  logic [SW-1:0] step_sat;
  assign step_sat = (iter_res > NUM_W'(slu_pkg::STEP_CAP)) ? slu_pkg::STEP_CAP
                                                          : iter_res[SW-1:0];

  // move a speed by a magnitude in the given direction
  logic [W+1:0] omega_mv, x_mv, y_mv;
  assign omega_mv = {{2{w_q[W-1]}}, w_q}
                  + (sw_q ? -{1'b0, ang_q[W:0]} : {1'b0, ang_q[W:0]});
  assign x_mv = {{2{vx_q[W-1]}}, vx_q} + (sx_q ? -{1'b0, qx_q} : {1'b0, qx_q});
  assign y_mv = {{2{vy_q[W-1]}}, vy_q}
              + (sy_q ? -{1'b0, iter_res[W:0]} : {1'b0, iter_res[W:0]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      job_q   <= JOB_LIN;
      vx_q    <= '0;
      vy_q    <= '0;
      w_q     <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            if (req_i.cmd == slu_pkg::CMD_CLEAR) begin
              vx_q    <= '0;
              vy_q    <= '0;
              w_q     <= '0;
              state_q <= ST_OUT;
            end else begin
              job_q   <= JOB_LIN;
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL:    state_q <= (job_q == JOB_ROOT) ? ST_SQY : ST_GO;
        ST_SQY:    state_q <= ST_GO;
        ST_GO:     state_q <= ST_WAIT;
        ST_WAIT: begin
          if (iter_done) begin
            unique case (job_q)
              JOB_LIN: begin
                job_q   <= JOB_ANG;
                state_q <= ST_MUL;
              end
              JOB_ANG: begin
                job_q   <= JOB_ROOT;
                state_q <= ST_MUL;
              end
              JOB_ROOT: state_q <= ST_DECIDE;
              JOB_QX: begin
                job_q   <= JOB_QY;
                state_q <= ST_MUL;
              end
              JOB_QY: begin
                vx_q    <= x_mv[W-1:0];
                vy_q    <= y_mv[W-1:0];
                state_q <= ST_OUT;
              end
              default: state_q <= ST_OUT;
            endcase
          end
        end
        ST_DECIDE: begin
          // angular rate: jump when closer than one step
          if (SW'(aw_q) < ang_q) begin
            w_q <= tw_q;
          end else begin
            w_q <= omega_mv[W-1:0];
          end
          // floor(root) < step is the same test as distance squared < step squared
          if (SW'(r_q) < lin_q) begin
            vx_q    <= tx_q;
            vy_q    <= ty_q;
            state_q <= ST_OUT;
          end else if (lin_q == '0) begin
            state_q <= ST_OUT;
          end else begin
            job_q   <= JOB_QX;
            state_q <= ST_MUL;
          end
        end
        ST_OUT:    if (rsp_o.ready) state_q <= ST_IDLE;
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && req_i.valid) begin
      tx_q <= req_i.target_vx;
      ty_q <= req_i.target_vy;
      tw_q <= req_i.target_omega;
      sx_q <= dx[W];
      sy_q <= dy[W];
      sw_q <= dw[W];
      ax_q <= dx[W] ? -dx : dx;
      ay_q <= dy[W] ? -dy : dy;
      aw_q <= dw[W] ? -dw : dw;
    end
    if (state_q == ST_MUL) begin
      prod_q <= mul_p;
    end else if (state_q == ST_SQY) begin
      prod_q <= prod_q + mul_p;
    end
    if (state_q == ST_WAIT && iter_done) begin
      if (job_q == JOB_LIN)  lin_q <= step_sat;
      if (job_q == JOB_ANG)  ang_q <= step_sat;
      if (job_q == JOB_ROOT) r_q   <= iter_res[W:0];
      if (job_q == JOB_QX)   qx_q  <= iter_res[W:0];
    end
  end

  assign req_i.ready     = (state_q == ST_IDLE);
  assign rsp_o.valid     = (state_q == ST_OUT);
  assign rsp_o.out_vx    = vx_q;
  assign rsp_o.out_vy    = vy_q;
  assign rsp_o.out_omega = w_q;
endmodule

### hw/rtl/slu_checker.sv
module slu_checker #(
  parameter int W = 24
) (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         req_valid_i,
  input logic         req_ready_i,
  input logic         req_cmd_i,
  input logic         rsp_valid_i,
  input logic         rsp_ready_i,
  input logic [W-1:0] rsp_vx_i,
  input logic [W-1:0] rsp_vy_i,
  input logic [W-1:0] rsp_omega_i
);
  logic req_fire;
  assign req_fire = req_valid_i && req_ready_i;

  // one request in flight at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_ready_i && rsp_valid_i))
    else $error("request taken while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> !req_ready_i)
    else $error("ready after acceptance");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && (req_cmd_i == slu_pkg::CMD_CLEAR) |=>
      (rsp_valid_i && rsp_vx_i == '0 && rsp_vy_i == '0 && rsp_omega_i == '0))
    else $error("clear request did not return zero speeds");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(rsp_vx_i) && $stable(rsp_vy_i) && $stable(rsp_omega_i))
    else $error("stalled result changed");
endmodule

bind planar_velocity_slew_limiter_unit slu_checker #(.W(SPEED_WIDTH)) u_slu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_cmd_i   (req_i.cmd),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_vx_i    (rsp_o.out_vx),
  .rsp_vy_i    (rsp_o.out_vy),
  .rsp_omega_i (rsp_o.out_omega)
);
